>>> design/hsl_pkg.sv
// Package for the HSL to RGB pixel converter: pixel item types, fixed-point
// constants, the hue weight function and the channel scaling function.
// Depends on nothing.
package hsl_pkg;

    // Fixed-point format of the inputs.
    localparam int FRACTION_BITS = 12;
    localparam int IN_W          = FRACTION_BITS + 1;
    localparam int ONE           = 1 << FRACTION_BITS;
    localparam int SIXTH         = 1 << (FRACTION_BITS - 2);
    localparam int TURN          = 6 * SIXTH;
    localparam int HALF          = ONE / 2;
    localparam int WEIGHT_W      = FRACTION_BITS - 1;

    // Internal widths of the datapath.
    localparam int MUL_IN_W = IN_W + 2;
    localparam int PQ_W     = 2 * MUL_IN_W;
    localparam int NUM_W    = PQ_W + WEIGHT_W + 1;
    localparam int SCALED_W = NUM_W + 8;
    localparam int DEN_SHIFT = 2 * FRACTION_BITS + (FRACTION_BITS - 2);

    // Input item: one HSL pixel.
    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] lightness;
    } hsl_t;

    // Result item: one RGB pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Weight of (q - p) in units of 1/SIXTH for a wrapped hue position t.
    function automatic logic [WEIGHT_W:0] hue_weight(input logic [IN_W-1:0] t);
        logic [IN_W-1:0] down;
        down = IN_W'(4 * SIXTH) - t;
        if (t < IN_W'(SIXTH))
            return (WEIGHT_W + 1)'(t);
        else if (t < IN_W'(3 * SIXTH))
            return (WEIGHT_W + 1)'(SIXTH);
        else if (t < IN_W'(4 * SIXTH))
            return (WEIGHT_W + 1)'(down);
        else
            return '0;
    endfunction

    // Scale a numerator over ONE*ONE*SIXTH by 255, truncate and saturate.
    function automatic logic [7:0] scale_channel(input logic signed [NUM_W-1:0] num);
        logic signed [SCALED_W-1:0] wide;
        logic signed [SCALED_W-1:0] scaled;
        logic [SCALED_W-DEN_SHIFT-1:0] whole;
        wide   = SCALED_W'(num);
        scaled = (wide <<< 8) - wide;
        whole  = scaled[SCALED_W-1:DEN_SHIFT];
        if (num <= 0)
            return 8'd0;
        else if (whole > (SCALED_W - DEN_SHIFT)'(255))
            return 8'd255;
        else
            return whole[7:0];
    endfunction

endpackage

>>> design/hsl_to_rgb_pixel_converter.sv
// Top level of the HSL to RGB pixel converter: a six-stage pipeline that turns
// one HSL pixel into one 8-bit RGB pixel. Depends on hsl_pkg.
//
// Usage:
//   Input channel: drive an HSL pixel on hsl and raise start for one cycle; the
//   item is taken at that clock edge when busy is low. busy is always low, so
//   a new item may enter on every clock cycle.
//   Result channel: each item yields one RGB pixel on rgb, shown for exactly
//   one cycle with done high. The receiver cannot stall the block and must
//   take the item in that cycle.
//   Pipeline: an item is registered in turn as operands, q product, p and slope,
//   channel products, numerators and the output register that drives rgb.
//   Throughput: one item per clock cycle through the single pipeline, which has
//   no stall; its multipliers are the q/p product, then one per channel.
//   Reset: rst_n low clears the valid bits of every stage, so items in flight
//   are dropped and done stays low until new items pass through. The data
//   registers of the stages have no reset.
//   Hue is taken modulo one turn (6144); saturation and lightness above 1.0
//   are used as given and the channel result is saturated to 0..255.
module hsl_to_rgb_pixel_converter
    import hsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  hsl_t hsl,
    output logic done,
    output rgb_t rgb
);

    // Valid bits that travel with the stages.
    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    // Stage 1: hue wrap and multiplier operands.
    logic [IN_W-1:0]            h1_reg, h1_next;
    logic [IN_W-1:0]            l1_reg;
    logic                       low1_reg, low1_next;
    logic signed [MUL_IN_W-1:0] ma1_reg, ma1_next;
    logic signed [MUL_IN_W-1:0] mb1_reg, mb1_next;

    // Stage 2: q/p product and channel weights.
    logic signed [PQ_W-1:0]   prod2_reg, prod2_next;
    logic [IN_W-1:0]          l2_reg;
    logic                     low2_reg;
    logic [WEIGHT_W:0]        w2_reg [3];
    logic [WEIGHT_W:0]        w2_next [3];
    logic [IN_W-1:0]          t_red;
    logic [IN_W-1:0]          t_blue;

    // Stage 3: p and (q - p).
    logic signed [PQ_W-1:0] p3_reg, p3_next;
    logic signed [PQ_W-1:0] d3_reg, d3_next;
    logic signed [PQ_W-1:0] q_val;
    logic [WEIGHT_W:0]      w3_reg [3];

    // Stage 4: per-channel products.
    logic signed [PQ_W-1:0]  p4_reg;
    logic signed [NUM_W-1:0] prod4_reg [3];
    logic signed [NUM_W-1:0] prod4_next [3];

    // Stage 5: per-channel numerators.
    logic signed [NUM_W-1:0] num5_reg [3];
    logic signed [NUM_W-1:0] num5_next [3];

    // Stage 6: output register.
    rgb_t rgb_reg, rgb_next;

    assign busy = 1'b0;
    assign done = valid_reg[5];
    assign rgb  = rgb_reg;

    // Valid bits shift with every clock.
    assign valid_next = {valid_reg[4:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: wrap hue into one turn and choose the operands for q.
    always_comb
    begin
        h1_next   = (hsl.hue >= IN_W'(TURN)) ? hsl.hue - IN_W'(TURN) : hsl.hue;
        low1_next = (hsl.lightness < IN_W'(HALF));
        if (low1_next)
        begin
            ma1_next = $signed({2'b00, hsl.lightness});
            mb1_next = $signed(MUL_IN_W'(ONE)) + $signed({2'b00, hsl.saturation});
        end
        else
        begin
            ma1_next = $signed(MUL_IN_W'(ONE)) - $signed({2'b00, hsl.lightness});
            mb1_next = $signed(MUL_IN_W'(ONE)) - $signed({2'b00, hsl.saturation});
        end
    end

    always_ff @(posedge clk)
    begin
        h1_reg   <= h1_next;
        l1_reg   <= hsl.lightness;
        low1_reg <= low1_next;
        ma1_reg  <= ma1_next;
        mb1_reg  <= mb1_next;
    end

    // Stage 2: the q product and the hue weight of each channel.
    always_comb
    begin
        prod2_next = PQ_W'(ma1_reg) * PQ_W'(mb1_reg);
        t_red      = h1_reg + IN_W'(2 * SIXTH);
        if (t_red >= IN_W'(TURN))
            t_red = t_red - IN_W'(TURN);
        if (h1_reg < IN_W'(2 * SIXTH))
            t_blue = h1_reg + IN_W'(4 * SIXTH);
        else
            t_blue = h1_reg - IN_W'(2 * SIXTH);
        w2_next[0] = hue_weight(t_red);
        w2_next[1] = hue_weight(h1_reg);
        w2_next[2] = hue_weight(t_blue);
    end

    always_ff @(posedge clk)
    begin
        prod2_reg <= prod2_next;
        l2_reg    <= l1_reg;
        low2_reg  <= low1_reg;
        for (int i = 0; i < 3; i++)
        begin
            w2_reg[i] <= w2_next[i];
        end
    end

    // Stage 3: q, p = 2L - q and the slope q - p, all over ONE*ONE.
    always_comb
    begin
        if (low2_reg)
            q_val = prod2_reg;
        else
            q_val = $signed(PQ_W'(ONE * ONE)) - prod2_reg;
        p3_next = $signed(PQ_W'({l2_reg, (FRACTION_BITS + 1)'(0)})) - q_val;
        d3_next = q_val - p3_next;
    end

    always_ff @(posedge clk)
    begin
        p3_reg <= p3_next;
        d3_reg <= d3_next;
        for (int i = 0; i < 3; i++)
        begin
            w3_reg[i] <= w2_reg[i];
        end
    end

    // Stage 4: slope times weight for each channel.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod4_next[i] = NUM_W'(d3_reg) * NUM_W'($signed({1'b0, w3_reg[i]}));
        end
    end

    always_ff @(posedge clk)
    begin
        p4_reg <= p3_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod4_reg[i] <= prod4_next[i];
        end
    end

    // Stage 5: numerator p*SIXTH + slope*weight over ONE*ONE*SIXTH.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num5_next[i] = (NUM_W'(p4_reg) <<< (FRACTION_BITS - 2)) + prod4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num5_reg[i] <= num5_next[i];
        end
    end

    // Stage 6: scale by 255, truncate and saturate into the output register.
    always_comb
    begin
        rgb_next.red   = scale_channel(num5_reg[0]);
        rgb_next.green = scale_channel(num5_reg[1]);
        rgb_next.blue  = scale_channel(num5_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

`ifndef NO_ASSERTIONS
    // An accepted item always comes out as a result with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted item did not produce a result");

    // No result appears without a matching accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6))
        else $error("result without a matching item");

    // Zero saturation gives a gray pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(hsl.saturation, 6) == '0) |->
            (rgb.red == rgb.green && rgb.green == rgb.blue))
        else $error("zero saturation did not give gray");

    // Zero lightness gives black.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(hsl.lightness, 6) == '0) |-> (rgb == '0))
        else $error("zero lightness did not give black");
`endif

endmodule
